@@ rtl/eds_pkg.sv @@
`default_nettype none

package eds_pkg;

  localparam int unsigned DayW  = 5;
  localparam int unsigned MonW  = 4;
  localparam int unsigned YearW = 12;
  localparam int unsigned SecW  = 32;
  localparam int unsigned AccW  = SecW + 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = YearW;

  localparam int unsigned DefaultLastYear = 2099;

  localparam logic [YearW-1:0] FirstYear = YearW'(1970);
  localparam logic [AccW-1:0]  SecsPerDay = AccW'(24 * 60 * 60);
  localparam logic [AccW-1:0]  SecsYear365 = AccW'(365 * 24 * 60 * 60);
  localparam logic [AccW-1:0]  SecsYear366 = AccW'(366 * 24 * 60 * 60);

  localparam logic [1:0] Mod4Init   = 2'(1970 % 4);
  localparam logic [6:0] Mod100Init = 7'(1970 % 100);
  localparam logic [8:0] Mod400Init = 9'(1970 % 400);
  localparam logic [6:0] Mod100Last = 7'd99;
  localparam logic [8:0] Mod400Last = 9'd399;

  localparam logic [MonW-1:0] January  = MonW'(1);
  localparam logic [MonW-1:0] February = MonW'(2);
  localparam logic [MonW-1:0] December = MonW'(12);
  localparam logic [DayW-1:0] FirstDay = DayW'(1);

  localparam logic [DayW-1:0]  ResetDay   = DayW'(1);
  localparam logic [MonW-1:0]  ResetMonth = MonW'(1);
  localparam logic [YearW-1:0] ResetYear  = FirstYear;

  typedef enum logic [0:0] {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDefaultDay   = 2'd0,
    CfgDefaultMonth = 2'd1,
    CfgDefaultYear  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StYear,
    StMonth,
    StDay
  } state_e;

  typedef enum logic [1:0] {
    StepYear,
    StepMonth,
    StepDay
  } step_e;

  typedef struct packed {
    logic            sub;
    step_e           sel;
    logic            leap;
    logic [MonW-1:0] month;
  } unit_ctl_t;

  typedef struct packed {
    logic [AccW-1:0] value;
    logic            ge;
  } unit_res_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m, input logic leap);
    logic [DayW-1:0] d;
    unique case (m)
      4'd2:                      d = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   d = DayW'(30);
      default:                   d = DayW'(31);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/eds_unit.sv @@
`default_nettype none

module eds_unit (
  input  logic [eds_pkg::AccW-1:0] acc_i,
  input  eds_pkg::unit_ctl_t       ctl_i,
  output eds_pkg::unit_res_t       res_o
);
  import eds_pkg::*;

  logic [AccW-1:0] step;
  logic [AccW-1:0] mon_secs;
  logic [AccW-1:0] operand;
  logic [AccW:0]   total;

  assign mon_secs = AccW'(month_days(ctl_i.month, ctl_i.leap)) * SecsPerDay;

  always_comb begin
    case (ctl_i.sel)
      StepYear:  step = ctl_i.leap ? SecsYear366 : SecsYear365;
      StepMonth: step = mon_secs;
      default:   step = SecsPerDay;
    endcase
  end

  assign operand = ctl_i.sub ? ~step : step;
  assign total   = {1'b0, acc_i} + {1'b0, operand} + {{AccW{1'b0}}, ctl_i.sub};

  assign res_o.value = total[AccW-1:0];
  assign res_o.ge    = total[AccW];

endmodule

`default_nettype wire

@@ rtl/eds_fsm.sv @@
`default_nettype none

module eds_fsm #(
  parameter int unsigned LastYear = eds_pkg::DefaultLastYear
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode_i,
  input  logic [1:0]                given_fields_i,
  input  logic [eds_pkg::DayW-1:0]  day_in_i,
  input  logic [eds_pkg::MonW-1:0]  month_in_i,
  input  logic [eds_pkg::YearW-1:0] year_in_i,
  input  logic [eds_pkg::SecW-1:0]  seconds_in_i,
  input  logic [eds_pkg::DayW-1:0]  def_day_i,
  input  logic [eds_pkg::MonW-1:0]  def_month_i,
  input  logic [eds_pkg::YearW-1:0] def_year_i,
  output logic                      done_o,
  output logic [eds_pkg::SecW-1:0]  seconds_out_o,
  output logic [eds_pkg::DayW-1:0]  day_out_o,
  output logic [eds_pkg::MonW-1:0]  month_out_o,
  output logic [eds_pkg::YearW-1:0] year_out_o,
  output logic                      range_error_o
);
  import eds_pkg::*;

  localparam logic [YearW-1:0] LastYr = YearW'(LastYear);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [DayW-1:0]  tday_q, tday_d;
  logic [MonW-1:0]  tmon_q, tmon_d;
  logic [YearW-1:0] tyr_q, tyr_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [YearW-1:0] y_q, y_d;
  logic [1:0]       c4_q, c4_d;
  logic [6:0]       c100_q, c100_d;
  logic [8:0]       c400_q, c400_d;
  logic [MonW-1:0]  m_q, m_d;
  logic [DayW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [SecW-1:0]  osec_q, osec_d;
  logic [DayW-1:0]  oday_q, oday_d;
  logic [MonW-1:0]  omon_q, omon_d;
  logic [YearW-1:0] oyr_q, oyr_d;
  logic             oerr_q, oerr_d;

  logic      leap;
  logic      req_bad;
  logic      day_bad;
  logic      is_dec;
  logic      finish;
  logic      fin_err;
  unit_ctl_t uctl;
  unit_res_t ures;

  assign leap    = (c4_q == 2'd0 && c100_q != 7'd0) || c400_q == 9'd0;
  assign is_dec  = (op_q == OpDecode);
  assign req_bad = tyr_q < FirstYear || tyr_q > LastYr || tmon_q < January || tmon_q > December;
  assign day_bad = tday_q < FirstDay || tday_q > month_days(tmon_q, leap);
  assign busy    = (state_q != StIdle);

  always_comb begin
    uctl.sub   = is_dec;
    uctl.leap  = leap;
    uctl.month = m_q;
    unique case (state_q)
      StYear:  uctl.sel = StepYear;
      StMonth: uctl.sel = StepMonth;
      default: uctl.sel = StepDay;
    endcase
  end

  eds_unit u_unit (
    .acc_i (acc_q),
    .ctl_i (uctl),
    .res_o (ures)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start) state_d = StSetup;
      StSetup: begin
        if (!is_dec && req_bad) state_d = StIdle;
        else state_d = StYear;
      end
      StYear: begin
        if (is_dec) begin
          if (!ures.ge) state_d = (y_q > LastYr) ? StIdle : StMonth;
        end else if (y_q == tyr_q) begin
          state_d = day_bad ? StIdle : StMonth;
        end
      end
      StMonth: begin
        if (is_dec) begin
          if (!(m_q < December && ures.ge)) state_d = StDay;
        end else if (m_q == tmon_q) begin
          state_d = StDay;
        end
      end
      StDay: begin
        if (is_dec) begin
          if (!ures.ge) state_d = StIdle;
        end else if (cnt_q == tday_q) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    op_d   = op_q;
    tday_d = tday_q;
    tmon_d = tmon_q;
    tyr_d  = tyr_q;
    acc_d  = acc_q;
    y_d    = y_q;
    c4_d   = c4_q;
    c100_d = c100_q;
    c400_d = c400_q;
    m_d    = m_q;
    cnt_d  = cnt_q;
    finish  = 1'b0;
    fin_err = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          op_d   = op_e'(opcode_i);
          tday_d = (given_fields_i >= 2'd1) ? day_in_i : def_day_i;
          tmon_d = (given_fields_i >= 2'd2) ? month_in_i : def_month_i;
          tyr_d  = (given_fields_i >= 2'd3) ? year_in_i : def_year_i;
          acc_d  = (op_e'(opcode_i) == OpDecode) ? {1'b0, seconds_in_i} : '0;
          y_d    = FirstYear;
          c4_d   = Mod4Init;
          c100_d = Mod100Init;
          c400_d = Mod400Init;
          m_d    = January;
          cnt_d  = FirstDay;
        end
      end
      StSetup: begin
        if (!is_dec && req_bad) begin
          finish  = 1'b1;
          fin_err = 1'b1;
        end
      end
      StYear: begin
        if ((is_dec && ures.ge) || (!is_dec && y_q != tyr_q)) begin
          acc_d  = ures.value;
          y_d    = y_q + YearW'(1);
          c4_d   = c4_q + 2'd1;
          c100_d = (c100_q == Mod100Last) ? 7'd0 : c100_q + 7'd1;
          c400_d = (c400_q == Mod400Last) ? 9'd0 : c400_q + 9'd1;
        end else if (is_dec && y_q > LastYr) begin
          finish  = 1'b1;
          fin_err = 1'b1;
        end else if (!is_dec && day_bad) begin
          finish  = 1'b1;
          fin_err = 1'b1;
        end
      end
      StMonth: begin
        if ((is_dec && m_q < December && ures.ge) || (!is_dec && m_q != tmon_q)) begin
          acc_d = ures.value;
          m_d   = m_q + MonW'(1);
        end
      end
      StDay: begin
        if ((is_dec && ures.ge) || (!is_dec && cnt_q != tday_q)) begin
          acc_d = ures.value;
          cnt_d = cnt_q + DayW'(1);
        end else begin
          finish  = 1'b1;
          fin_err = !is_dec && acc_q[AccW-1];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    done_d = finish;
    osec_d = osec_q;
    oday_d = oday_q;
    omon_d = omon_q;
    oyr_d  = oyr_q;
    oerr_d = oerr_q;
    if (finish) begin
      oerr_d = fin_err;
      osec_d = (!is_dec && !fin_err) ? acc_q[SecW-1:0] : '0;
      oday_d = (is_dec && !fin_err) ? cnt_q : '0;
      omon_d = (is_dec && !fin_err) ? m_q : '0;
      oyr_d  = (is_dec && !fin_err) ? y_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    tday_q <= tday_d;
    tmon_q <= tmon_d;
    tyr_q  <= tyr_d;
    acc_q  <= acc_d;
    y_q    <= y_d;
    c4_q   <= c4_d;
    c100_q <= c100_d;
    c400_q <= c400_d;
    m_q    <= m_d;
    cnt_q  <= cnt_d;
    osec_q <= osec_d;
    oday_q <= oday_d;
    omon_q <= omon_d;
    oyr_q  <= oyr_d;
    oerr_q <= oerr_d;
  end

  assign done_o        = done_q;
  assign seconds_out_o = osec_q;
  assign day_out_o     = oday_q;
  assign month_out_o   = omon_q;
  assign year_out_o    = oyr_q;
  assign range_error_o = oerr_q;

`ifndef NO_ASSERTIONS
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) != StIdle && state_q == StIdle)
    else $error("result beat without a finishing step");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not start work");

  a_month_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMonth || state_q == StDay) |-> m_q >= January && m_q <= December)
    else $error("month counter out of range");

  a_err_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && range_error_o |-> seconds_out_o == '0 && day_out_o == '0 &&
      month_out_o == '0 && year_out_o == '0)
    else $error("error beat carries nonzero fields");

  a_year_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDay |-> y_q >= FirstYear && y_q <= LastYr)
    else $error("year counter out of range in day walk");
`endif

endmodule

`default_nettype wire

@@ rtl/epoch_date_seconds_converter_core.sv @@
// Channel | Fields                                                 | Beat taken on
// request | opcode given_fields day_in month_in year_in seconds_in | start & !busy
// config  | cfg_index_i cfg_data_i                                 | cfg_valid_i & cfg_ready_o
// result  | seconds_out day_out month_out year_out range_error     | done_o, one cycle
// One shared add/subtract unit walks years, then months, then days, one step a cycle.
// busy stays high from a request beat through setup and the year, month and day walks;
// a bad encode date caught in setup finishes there, without a walk.
// busy drops in the cycle done_o pulses, so the next start may land there.
// The receiver cannot stall; done_o lasts one cycle.
// rst_ni clears the sequencer, the strobe and the default-date registers.
`default_nettype none

module epoch_date_seconds_converter_core #(
  parameter int unsigned LastYear = eds_pkg::DefaultLastYear
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode_i,
  input  logic [1:0]                   given_fields_i,
  input  logic [eds_pkg::DayW-1:0]     day_in_i,
  input  logic [eds_pkg::MonW-1:0]     month_in_i,
  input  logic [eds_pkg::YearW-1:0]    year_in_i,
  input  logic [eds_pkg::SecW-1:0]     seconds_in_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [eds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [eds_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         done_o,
  output logic [eds_pkg::SecW-1:0]     seconds_out_o,
  output logic [eds_pkg::DayW-1:0]     day_out_o,
  output logic [eds_pkg::MonW-1:0]     month_out_o,
  output logic [eds_pkg::YearW-1:0]    year_out_o,
  output logic                         range_error_o
);
  import eds_pkg::*;

  logic [DayW-1:0]  def_day_q, def_day_d;
  logic [MonW-1:0]  def_mon_q, def_mon_d;
  logic [YearW-1:0] def_yr_q, def_yr_d;
  logic             cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    def_day_d = def_day_q;
    def_mon_d = def_mon_q;
    def_yr_d  = def_yr_q;
    if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgDefaultDay:   def_day_d = cfg_data_i[DayW-1:0];
        CfgDefaultMonth: def_mon_d = cfg_data_i[MonW-1:0];
        CfgDefaultYear:  def_yr_d  = cfg_data_i[YearW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_day_q <= ResetDay;
      def_mon_q <= ResetMonth;
      def_yr_q  <= ResetYear;
    end else begin
      def_day_q <= def_day_d;
      def_mon_q <= def_mon_d;
      def_yr_q  <= def_yr_d;
    end
  end

  eds_fsm #(
    .LastYear (LastYear)
  ) u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .given_fields_i (given_fields_i),
    .day_in_i       (day_in_i),
    .month_in_i     (month_in_i),
    .year_in_i      (year_in_i),
    .seconds_in_i   (seconds_in_i),
    .def_day_i      (def_day_q),
    .def_month_i    (def_mon_q),
    .def_year_i     (def_yr_q),
    .done_o         (done_o),
    .seconds_out_o  (seconds_out_o),
    .day_out_o      (day_out_o),
    .month_out_o    (month_out_o),
    .year_out_o     (year_out_o),
    .range_error_o  (range_error_o)
  );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eds_pkg::*;

  localparam int unsigned LastYear = DefaultLastYear;
  localparam longint unsigned DaySeconds = 24 * 60 * 60;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ItemsPerPhase = 115;
  localparam int unsigned PhaseCount = 10;

  typedef struct packed {
    op_e              opcode;
    logic [1:0]       given;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    logic [SecW-1:0]  seconds;
  } conv_req_t;

  typedef struct packed {
    logic [SecW-1:0]  seconds;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    logic             range_error;
  } conv_res_t;

  class epoch_scoreboard;
    conv_res_t   conversions_due[$];
    int unsigned mismatches = 0;
    int unsigned default_day = 1;
    int unsigned default_month = 1;
    int unsigned default_year = 1970;

    function bit leap_rule(int unsigned y);
      return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function int unsigned year_length(int unsigned y);
      return leap_rule(y) ? 366 : 365;
    endfunction

    function int unsigned month_length(int unsigned m, int unsigned y);
      case (m)
        2:           return leap_rule(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function longint unsigned days_since_epoch(int unsigned d, int unsigned m, int unsigned y);
      longint unsigned days;
      days = 0;
      for (int unsigned yy = 1970; yy < y; yy++) days += year_length(yy);
      for (int unsigned mm = 1; mm < m; mm++) days += month_length(mm, y);
      return days + d - 1;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgDefaultDay:   default_day = int'(data[DayW-1:0]);
        CfgDefaultMonth: default_month = int'(data[MonW-1:0]);
        CfgDefaultYear:  default_year = int'(data[YearW-1:0]);
        default:         ;
      endcase
    endfunction

    function conv_res_t convert(conv_req_t r);
      conv_res_t       e;
      int unsigned     d, m, y, days;
      longint unsigned total;
      e = '0;
      if (r.opcode == OpEncode) begin
        d = r.given >= 1 ? int'(r.day) : default_day;
        m = r.given >= 2 ? int'(r.month) : default_month;
        y = r.given >= 3 ? int'(r.year) : default_year;
        if (y < 1970 || y > LastYear || m < 1 || m > 12 || d < 1 ||
            d > month_length(m, y)) begin
          e.range_error = 1'b1;
        end else begin
          total = days_since_epoch(d, m, y) * DaySeconds;
          if (total > 64'hFFFF_FFFF) e.range_error = 1'b1;
          else e.seconds = total[SecW-1:0];
        end
      end else begin
        days = r.seconds / 32'(DaySeconds);
        y = 1970;
        m = 1;
        while (days >= year_length(y)) begin
          days -= year_length(y);
          y++;
        end
        if (y > LastYear) begin
          e.range_error = 1'b1;
        end else begin
          while (m < 12 && days >= month_length(m, y)) begin
            days -= month_length(m, y);
            m++;
          end
          e.day = DayW'(days + 1);
          e.month = MonW'(m);
          e.year = YearW'(y);
        end
      end
      return e;
    endfunction

    function void note_conversion(conv_req_t r);
      conversions_due.push_back(convert(r));
    endfunction

    function void check_conversion(conv_res_t got);
      conv_res_t want;
      if (conversions_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected conversion result: sec=%0d day=%0d mon=%0d year=%0d err=%0b",
                   got.seconds, got.day, got.month, got.year, got.range_error);
        mismatches++;
        return;
      end
      want = conversions_due.pop_front();
      if (got.seconds !== want.seconds || got.day !== want.day || got.month !== want.month ||
          got.year !== want.year || got.range_error !== want.range_error) begin
        if (mismatches < 10)
          $display("conversion mismatch: expected sec=%0d day=%0d mon=%0d year=%0d err=%0b,",
                   want.seconds, want.day, want.month, want.year, want.range_error,
                   " got sec=%0d day=%0d mon=%0d year=%0d err=%0b",
                   got.seconds, got.day, got.month, got.year, got.range_error);
        mismatches++;
      end
    endfunction

    function void count_leftovers();
      mismatches += conversions_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = 1'b0;
  logic [1:0] given_fields_i = '0;
  logic [DayW-1:0] day_in_i = '0;
  logic [MonW-1:0] month_in_i = '0;
  logic [YearW-1:0] year_in_i = '0;
  logic [SecW-1:0] seconds_in_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic done_o;
  logic [SecW-1:0] seconds_out_o;
  logic [DayW-1:0] day_out_o;
  logic [MonW-1:0] month_out_o;
  logic [YearW-1:0] year_out_o;
  logic range_error_o;

  int unsigned idle_cycles = 0;
  epoch_scoreboard sb = new();

  epoch_date_seconds_converter_core #(
    .LastYear(LastYear)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .given_fields_i(given_fields_i),
    .day_in_i      (day_in_i),
    .month_in_i    (month_in_i),
    .year_in_i     (year_in_i),
    .seconds_in_i  (seconds_in_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .seconds_out_o (seconds_out_o),
    .day_out_o     (day_out_o),
    .month_out_o   (month_out_o),
    .year_out_o    (year_out_o),
    .range_error_o (range_error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_conversion('{seconds_out_o, day_out_o, month_out_o, year_out_o, range_error_o});
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("epoch_date_seconds_converter_core regression: fail");
    $finish;
  end

  task automatic send_request(conv_req_t r);
    start <= 1'b1;
    opcode_i <= r.opcode;
    given_fields_i <= r.given;
    day_in_i <= r.day;
    month_in_i <= r.month;
    year_in_i <= r.year;
    seconds_in_i <= r.seconds;
    do @(posedge clk_i); while (busy);
    sb.note_conversion(r);
  endtask

  task automatic hold_requests(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_conversions();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.conversions_due.size() != 0);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
  endtask

  task automatic program_defaults(int unsigned d, int unsigned m, int unsigned y, bit idle_ok);
    logic [CfgDataW-1:0] data;
    data = CfgDataW'($urandom);
    data[DayW-1:0] = DayW'(d);
    write_register(CfgDefaultDay, data);
    if (idle_ok && $urandom_range(0, 99) < 16) begin
      cfg_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    data = CfgDataW'($urandom);
    data[MonW-1:0] = MonW'(m);
    write_register(CfgDefaultMonth, data);
    write_register(CfgDefaultYear, CfgDataW'(y));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic encode_date(int unsigned given, int unsigned d, int unsigned m, int unsigned y);
    conv_req_t r;
    r = '0;
    r.opcode = OpEncode;
    r.given = 2'(given);
    r.day = DayW'(d);
    r.month = MonW'(m);
    r.year = YearW'(y);
    send_request(r);
  endtask

  task automatic decode_seconds(logic [SecW-1:0] s);
    conv_req_t r;
    r = '0;
    r.opcode = OpDecode;
    r.seconds = s;
    send_request(r);
  endtask

  function automatic conv_req_t random_request();
    conv_req_t       r;
    int unsigned     pick, d, m, y;
    longint unsigned top;
    r.opcode = OpEncode;
    r.given = 2'($urandom_range(0, 3));
    r.day = DayW'($urandom);
    r.month = MonW'($urandom);
    r.year = YearW'($urandom);
    r.seconds = $urandom;
    y = $urandom_range(1970, LastYear);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, sb.month_length(m, y));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.day = DayW'(d);
      r.month = MonW'(m);
      r.year = YearW'(y);
    end else if (pick < 55) begin
      if ($urandom_range(0, 1)) r.year = YearW'($urandom_range(1965, LastYear + 6));
    end else if (pick < 75) begin
      r.opcode = OpDecode;
      case ($urandom_range(0, 2))
        0:       r.seconds = 32'(sb.days_since_epoch(d, m, y) * DaySeconds);
        1:       r.seconds = 32'(sb.days_since_epoch(d, m, y) * DaySeconds + DaySeconds - 1);
        default: r.seconds = 32'(sb.days_since_epoch(d, m, y) * DaySeconds +
                                 $urandom_range(0, DaySeconds - 1));
      endcase
    end else if (pick < 90) begin
      r.opcode = OpDecode;
    end else begin
      r.opcode = OpDecode;
      top = sb.days_since_epoch(1, 1, LastYear + 1) * DaySeconds;
      r.seconds = 32'(top - 1000 + $urandom_range(0, 2000));
    end
    return r;
  endfunction

  initial begin
    int unsigned d, m, y;
    bit          idle_ok;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    encode_date(0, 9, 9, 2050);
    encode_date(3, 1, 1, 1970);
    encode_date(3, 31, 12, LastYear);
    encode_date(3, 29, 2, 2000);
    encode_date(3, 29, 2, 2001);
    encode_date(3, 31, 4, 2024);
    encode_date(3, 0, 6, 1999);
    encode_date(3, 10, 0, 1999);
    encode_date(3, 10, 13, 1999);
    encode_date(3, 31, 15, 1999);
    encode_date(3, 31, 12, 0);
    encode_date(3, 1, 1, 4095);
    encode_date(3, 31, 12, 1969);
    encode_date(3, 1, 1, LastYear + 1);
    encode_date(1, 15, 15, 4095);
    encode_date(2, 10, 7, 0);
    decode_seconds(32'd0);
    decode_seconds(32'd86399);
    decode_seconds(32'd86400);
    decode_seconds(32'd31535999);
    decode_seconds(32'd951782400);
    decode_seconds(32'd4102444799);
    decode_seconds(32'd4102444800);
    decode_seconds(32'hFFFF_FFFF);

    for (int unsigned phase = 1; phase <= PhaseCount; phase++) begin
      idle_ok = (phase != 6);
      drain_conversions();
      case (phase)
        1: begin d = 31; m = 12; y = LastYear; end
        2: begin d = 1; m = 1; y = 1970; end
        3: begin d = 0; m = 0; y = 0; end
        4: begin d = 31; m = 15; y = 4095; end
        5: begin d = 29; m = 2; y = 2000; end
        default: begin
          if ($urandom_range(0, 3) != 0) begin
            y = $urandom_range(1970, LastYear);
            m = $urandom_range(1, 12);
            d = $urandom_range(1, sb.month_length(m, y));
          end else begin
            d = $urandom_range(0, 31);
            m = $urandom_range(0, 15);
            y = $urandom_range(0, 4095);
          end
        end
      endcase
      program_defaults(d, m, y, idle_ok);
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (idle_ok && $urandom_range(0, 99) < 16) hold_requests($urandom_range(1, 180));
        send_request(random_request());
      end
    end

    drain_conversions();
    repeat (200) @(posedge clk_i);
    sb.count_leftovers();
    if (sb.mismatches == 0) begin
      $display("epoch_date_seconds_converter_core regression: pass");
    end else begin
      $display("epoch_date_seconds_converter_core regression: fail");
    end
    $finish;
  end

endmodule
